// File: rtl/vln_pkg.sv
// Package for the vector length normalizer: widths, stage payload types.
// Used by the interfaces, the root and divide stages and the top level.
`default_nettype none
package vln_pkg;

    localparam int CW   = 16;            // component width, Q8.8
    localparam int UF   = 14;            // fraction bits of a unit result
    localparam int UW   = 16;            // unit output width
    localparam int MW   = 17;            // magnitude output width
    localparam int SQW  = 2 * CW;        // one square
    localparam int SUMW = SQW + 2;       // sum of four squares
    localparam int RW   = SUMW / 2;      // root width
    localparam int DQ   = UF + 1;        // quotient bits, quotient never exceeds 2^UF
    localparam int DCW  = RW + UF;       // divider remainder width
    localparam int DIMW = 3;             // dimension register width

    localparam logic [DIMW-1:0] DIM_RESET = 3'd3;

    typedef struct packed {
        logic [3:0][CW-1:0] mag;
        logic [3:0]         neg;
    } t_side;

    typedef struct packed {
        logic [SUMW-1:0] rem;
        logic [RW-1:0]   root;
        t_side           side;
    } t_sqrt;

    typedef struct packed {
        logic [RW-1:0]           len;
        logic [3:0]              neg;
        logic [3:0][DCW-1:0]     rem;
        logic [3:0][DQ-1:0]      quo;
    } t_div;

endpackage
`default_nettype wire

// File: rtl/vln_if.sv
// Handshake channels of the vector length normalizer: input vector and result.
// Depends on vln_pkg for the field widths.
`default_nettype none
interface vln_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [vln_pkg::CW-1:0]   comp_x;
    logic signed [vln_pkg::CW-1:0]   comp_y;
    logic signed [vln_pkg::CW-1:0]   comp_z;
    logic signed [vln_pkg::CW-1:0]   comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vln_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [vln_pkg::UW-1:0]   unit_x;
    logic signed [vln_pkg::UW-1:0]   unit_y;
    logic signed [vln_pkg::UW-1:0]   unit_z;
    logic signed [vln_pkg::UW-1:0]   unit_w;
    logic [vln_pkg::MW-1:0]          magnitude;
    logic                            zero_vector;

    modport source (output valid, unit_x, unit_y, unit_z, unit_w, magnitude,
                    zero_vector, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, magnitude,
                    zero_vector, output ready);
endinterface
`default_nettype wire

// File: rtl/vln_sqrt_stage.sv
// One registered step of the digit-by-digit square root: resolves root bit BIT.
// Depends on vln_pkg for the t_sqrt payload type.
`default_nettype none
module vln_sqrt_stage #(
    parameter int BIT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire vln_pkg::t_sqrt i_d,
    output vln_pkg::t_sqrt      o_q
);
    localparam int TW = vln_pkg::SUMW + 1;

    logic [TW-1:0]        trial;
    vln_pkg::t_sqrt       n_q;
    vln_pkg::t_sqrt       r_q;

    always_comb begin
        trial = (TW'(i_d.root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        n_q   = i_d;
        if (TW'(i_d.rem) >= trial) begin
            n_q.rem       = i_d.rem - vln_pkg::SUMW'(trial);
            n_q.root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// File: rtl/vln_div_stage.sv
// One registered restoring-division step for all four lanes: resolves quotient bit BIT.
// Depends on vln_pkg for the t_div payload type.
`default_nettype none
module vln_div_stage #(
    parameter int BIT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire vln_pkg::t_div i_d,
    output vln_pkg::t_div      o_q
);
    localparam int TW = vln_pkg::DCW + 1;

    logic [TW-1:0]  trial;
    vln_pkg::t_div  n_q;
    vln_pkg::t_div  r_q;

    always_comb begin
        trial = TW'(i_d.len) << BIT;
        n_q   = i_d;
        for (int l = 0; l < 4; l++) begin
            if (TW'(i_d.rem[l]) >= trial) begin
                n_q.rem[l]      = i_d.rem[l] - vln_pkg::DCW'(trial);
                n_q.quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// File: rtl/vector_length_normalize.sv
// Top level of the vector length normalizer.
// Depends on vln_pkg, the channel interfaces, vln_sqrt_stage and vln_div_stage.
`default_nettype none
// The block takes one vector of up to four signed Q8.8 components per transfer
// and returns its floor length and its components scaled to Q1.14 unit length.
// It is a pipeline that accepts one vector every cycle unless the output stalls;
// from input transfer to the result being offered it has one stage each for
// component capture, squaring and summing, one stage per root bit (17) and one
// stage per quotient bit (15) of the four parallel divider lanes, plus the
// output register. Stalls on the output only hold back the pipeline as far as
// it is full, so bubbles are squeezed out. The dimension register selects two,
// three or four components; codes below two act as two, codes above four act
// as four. Write it only while no vector is in flight.
module vector_length_normalize (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [vln_pkg::DIMW-1:0]     i_cfg_data,
    vln_in_if.sink                            i_in,
    vln_out_if.source                         o_out
);
    localparam int NS = 3 + vln_pkg::RW + vln_pkg::DQ;

    logic [vln_pkg::DIMW-1:0] r_dim;
    logic [NS-1:0]            r_v;
    logic [NS:0]              en;
    logic                     r_out_v;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= vln_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_data;
        end
    end

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb begin
        en[NS] = !r_out_v || o_out.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k + 1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
            if (en[NS]) begin
                r_out_v <= r_v[NS - 1];
            end
        end
    end

    // Capture: magnitude and sign of each used component; unused ones become zero.
    logic use_z;
    logic use_w;
    logic [3:0][vln_pkg::CW-1:0] comp;
    logic [3:0]                  use_c;
    vln_pkg::t_side              n_s0;
    vln_pkg::t_side              r_s0;

    assign use_z = (r_dim >= vln_pkg::DIMW'(3));
    assign use_w = (r_dim >= vln_pkg::DIMW'(4));
    assign comp  = {i_in.comp_w, i_in.comp_z, i_in.comp_y, i_in.comp_x};
    assign use_c = {use_w, use_z, 2'b11};

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_s0.neg[l] = use_c[l] & comp[l][vln_pkg::CW-1];
            if (!use_c[l]) begin
                n_s0.mag[l] = '0;
            end else if (comp[l][vln_pkg::CW-1]) begin
                n_s0.mag[l] = '0 - comp[l];
            end else begin
                n_s0.mag[l] = comp[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
    end

    // Squaring: one multiplier per lane.
    logic [3:0][vln_pkg::SQW-1:0] r_sq;
    vln_pkg::t_side               r_s1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int l = 0; l < 4; l++) begin
                r_sq[l] <= vln_pkg::SQW'(r_s0.mag[l]) * vln_pkg::SQW'(r_s0.mag[l]);
            end
            r_s1 <= r_s0;
        end
    end

    // Merge: the lanes' squares are summed into the root's radicand.
    vln_pkg::t_sqrt sq [vln_pkg::RW+1];
    vln_pkg::t_sqrt r_s2;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2.rem  <= vln_pkg::SUMW'(r_sq[0]) + vln_pkg::SUMW'(r_sq[1])
                       + vln_pkg::SUMW'(r_sq[2]) + vln_pkg::SUMW'(r_sq[3]);
            r_s2.root <= '0;
            r_s2.side <= r_s1;
        end
    end

    assign sq[0] = r_s2;

    // Square root, most significant root bit first.
    for (genvar k = 0; k < vln_pkg::RW; k++) begin : g_sqrt
        vln_sqrt_stage #(
            .BIT (vln_pkg::RW - 1 - k)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (en[3 + k]),
            .i_d   (sq[k]),
            .o_q   (sq[k + 1])
        );
    end

    // Divider lanes: each component times 2^UF over the length.
    vln_pkg::t_div dv [vln_pkg::DQ+1];

    always_comb begin
        dv[0].len = sq[vln_pkg::RW].root;
        dv[0].neg = sq[vln_pkg::RW].side.neg;
        for (int l = 0; l < 4; l++) begin
            dv[0].rem[l] = vln_pkg::DCW'(sq[vln_pkg::RW].side.mag[l]) << vln_pkg::UF;
            dv[0].quo[l] = '0;
        end
    end

    for (genvar j = 0; j < vln_pkg::DQ; j++) begin : g_div
        vln_div_stage #(
            .BIT (vln_pkg::DQ - 1 - j)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (en[3 + vln_pkg::RW + j]),
            .i_d   (dv[j]),
            .o_q   (dv[j + 1])
        );
    end

    // Output register: saturate, apply sign, and force zeros for a zero vector.
    localparam logic [vln_pkg::DQ-1:0] UNIT = vln_pkg::DQ'(1) << vln_pkg::UF;

    vln_pkg::t_div                  fin;
    logic                           is_zero;
    logic [3:0][vln_pkg::UW-1:0]    n_unit;
    logic [3:0][vln_pkg::UW-1:0]    r_unit;
    logic [vln_pkg::MW-1:0]         r_mag;
    logic                           r_zero;

    assign fin     = dv[vln_pkg::DQ];
    assign is_zero = (fin.len == '0);

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            logic [vln_pkg::DQ-1:0] q;
            q = (fin.quo[l] > UNIT) ? UNIT : fin.quo[l];
            if (is_zero) begin
                n_unit[l] = '0;
            end else if (fin.neg[l]) begin
                n_unit[l] = '0 - vln_pkg::UW'(q);
            end else begin
                n_unit[l] = vln_pkg::UW'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            r_unit <= n_unit;
            r_mag  <= vln_pkg::MW'(fin.len);
            r_zero <= is_zero;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.unit_x      = r_unit[0];
    assign o_out.unit_y      = r_unit[1];
    assign o_out.unit_z      = r_unit[2];
    assign o_out.unit_w      = r_unit[3];
    assign o_out.magnitude   = r_mag;
    assign o_out.zero_vector = r_zero;
endmodule
`default_nettype wire

// File: tb/tb_vln_checker.sv
// Result checker for the vector length normalizer: watches both channels,
// predicts each result from the accepted vector and compares field by field.
// Depends on vln_pkg and the channel interfaces in vln_if.sv.
module tb_vln_checker (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [vln_pkg::DIMW-1:0] i_cfg_data,
    vln_in_if.sink                        i_in,
    vln_out_if.sink                       i_out,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [vln_pkg::UW-1:0] ux, uy, uz, uw;
        logic [vln_pkg::MW-1:0] mag;
        logic                   zero;
    } t_unit_result;

    t_unit_result                expected_units[$];
    logic [vln_pkg::DIMW-1:0]    dim_reg;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [vln_pkg::UW-1:0] scale_comp(longint c, logic [63:0] len);
        logic [63:0] q, a;
        a = (c < 0) ? -c : c;
        q = (a << vln_pkg::UF) / len;
        if (q > (64'd1 << vln_pkg::UF)) q = 64'd1 << vln_pkg::UF;
        if (c < 0) q = -q;
        return q[vln_pkg::UW-1:0];
    endfunction

    function automatic t_unit_result normalize_vector(
            logic [vln_pkg::CW-1:0] x, y, z, w, logic [vln_pkg::DIMW-1:0] d);
        int           used;
        longint       c[4];
        logic [63:0]  sum, len;
        t_unit_result r;
        used = (int'(d) < 2) ? 2 : (int'(d) > 4) ? 4 : int'(d);
        c[0] = longint'($signed(x));
        c[1] = longint'($signed(y));
        c[2] = (used > 2) ? longint'($signed(z)) : 0;
        c[3] = (used > 3) ? longint'($signed(w)) : 0;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += c[i] * c[i];
        r = '0;
        if (sum == 0) begin
            r.zero = 1'b1;
            return r;
        end
        len = isqrt(sum);
        r.ux = scale_comp(c[0], len);
        r.uy = scale_comp(c[1], len);
        r.uz = scale_comp(c[2], len);
        r.uw = scale_comp(c[3], len);
        r.mag = len[vln_pkg::MW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    assign o_pending = expected_units.size();

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        t_unit_result e;
        if (!i_rst_n) begin
            dim_reg <= vln_pkg::DIM_RESET;
        end else begin
            if (i_cfg_we) dim_reg <= i_cfg_data;
            if (i_in.valid && i_in.ready)
                expected_units.push_back(normalize_vector(i_in.comp_x, i_in.comp_y,
                                         i_in.comp_z, i_in.comp_w, dim_reg));
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (expected_units.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    e = expected_units.pop_front();
                    if (i_out.unit_x !== e.ux)
                        report_mismatch("unit_x", 32'(i_out.unit_x), 32'(e.ux));
                    if (i_out.unit_y !== e.uy)
                        report_mismatch("unit_y", 32'(i_out.unit_y), 32'(e.uy));
                    if (i_out.unit_z !== e.uz)
                        report_mismatch("unit_z", 32'(i_out.unit_z), 32'(e.uz));
                    if (i_out.unit_w !== e.uw)
                        report_mismatch("unit_w", 32'(i_out.unit_w), 32'(e.uw));
                    if (i_out.magnitude !== e.mag)
                        report_mismatch("magnitude", 32'(i_out.magnitude), 32'(e.mag));
                    if (i_out.zero_vector !== e.zero)
                        report_mismatch("zero_vector", 32'(i_out.zero_vector),
                                        32'(e.zero));
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
// Top of the vector length normalizer testbench: clock, reset, stimulus and verdict.
// Depends on vln_pkg, vln_if.sv, tb_vln_checker and the vector_length_normalize RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [vln_pkg::DIMW-1:0] cfg_data;
    int                       errors, pending, results;
    int                       cycles;
    int                       vectors_sent;

    vln_in_if  in_ch();
    vln_out_if out_ch();

    vector_length_normalize dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    tb_vln_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in(in_ch.sink), .i_out(out_ch.sink),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog counts every rising edge; a hung pipeline ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side stalls by a random amount before every transfer, drawn as zero
    // more often than any other amount, so the pipeline also runs at full rate.
    // Ready stays high across transfers whose drawn wait is zero.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Offers one vector and holds it until the transfer happens. Valid is dropped
    // only during the sender's own gap, never in the same step it is raised again.
    task automatic send_vector(logic [vln_pkg::CW-1:0] x, y, z, w, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.comp_x <= x;
        in_ch.comp_y <= y;
        in_ch.comp_z <= z;
        in_ch.comp_w <= w;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        vectors_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_dimension(logic [vln_pkg::DIMW-1:0] d);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Half the components are full-range random, the rest zero, small or at the field
    // extremes, so the widest sums are exercised.
    function automatic logic [vln_pkg::CW-1:0] random_comp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return vln_pkg::CW'($urandom_range(0, 255) - 128);
            2: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            default: return vln_pkg::CW'($urandom);
        endcase
    endfunction

    initial begin
        logic [vln_pkg::DIMW-1:0] dims[8];
        int gap;
        vectors_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.comp_x = '0;
        in_ch.comp_y = '0;
        in_ch.comp_z = '0;
        in_ch.comp_w = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed vectors under the reset dimension of three: zero vector,
        // extremes, single axis (exact unit), and floored lengths that overshoot.
        send_vector(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_vector(16'h0000, 16'h0000, 16'h0000, 16'h1234, 0);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        send_vector(16'h0100, 16'h0000, 16'h0000, 16'h0000, 0);
        send_vector(16'hff00, 16'h0000, 16'h0000, 16'h0000, 0);
        send_vector(16'h0001, 16'h0001, 16'h0000, 16'h0000, 2);
        send_vector(16'h0001, 16'hffff, 16'h0001, 16'h0000, 0);
        send_vector(16'h0003, 16'h0004, 16'h0000, 16'h0000, 0);
        send_vector(16'h8000, 16'h7fff, 16'h0001, 16'h5555, 0);
        send_vector(16'h0000, 16'h0000, 16'h0002, 16'h0000, 3);
        write_dimension(3'd4);
        send_vector(16'h0000, 16'h0000, 16'h0000, 16'h0005, 0);
        send_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_vector(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
        write_dimension(3'd2);
        send_vector(16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 0);
        send_vector(16'h7fff, 16'h8000, 16'h1111, 16'h2222, 0);
        write_dimension(3'd0);
        send_vector(16'h0002, 16'h0003, 16'h4444, 16'h4444, 0);
        write_dimension(3'd1);
        send_vector(16'hfffe, 16'h0000, 16'h4444, 16'h4444, 0);
        write_dimension(3'd7);
        send_vector(16'h0001, 16'h0000, 16'h0000, 16'h0001, 0);
        write_dimension(3'd5);
        send_vector(16'h0000, 16'h0000, 16'h0000, 16'h8000, 0);

        // Random phases through dimension codes 0 to 4 and 6. The middle phase holds the
        // sender back until the pipeline has fully drained before continuing.
        dims = '{3'd2, 3'd4, 3'd3, 3'd6, 3'd0, 3'd4, 3'd1, 3'd2};
        for (int p = 0; p < 8; p++) begin
            write_dimension(dims[p]);
            for (int i = 0; i < 240; i++) begin
                if (p == 4 && i == 120) wait_idle();
                gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 10);
                send_vector(random_comp(), random_comp(), random_comp(),
                            random_comp(), gap);
            end
        end
        wait_idle();

        $display("Sent %0d vectors over all eight dimension codes; %0d results checked.",
                 vectors_sent, results);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
